### rtl/core/afs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the animation frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

  // field widths
  localparam int DEFAULT_MAX_FRAMES = 16;
  localparam int OP_W       = 2;
  localparam int ELAPSED_W  = 16;
  localparam int SLOT_W     = 4;
  localparam int DUR_W      = 16;
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 4;
  localparam int TIME_W     = 32;
  // sum of at most 31 durations of 16 bits
  localparam int PERIOD_W   = 21;
  localparam int DIV_CNT_W  = $clog2(TIME_W);
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // item operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_RESTART = 2'd1,
    OP_WRITE   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd1;

  // datapath commands
  typedef enum logic [3:0] {
    DP_NOP,
    DP_TICK_START,
    DP_RESTART,
    DP_WRITE,
    DP_STEP,
    DP_SUM_ACC,
    DP_DIV_START,
    DP_DIV_STEP,
    DP_OUT_LOAD
  } dp_op_e;

  // table read address source
  typedef enum logic {
    RD_CUR,
    RD_IDX
  } rd_sel_e;

  typedef struct packed {
    dp_op_e  op;
    rd_sel_e rd_sel;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic covers;
    logic last_frame;
    logic loop_en;
    logic sum_last;
    logic time_ge_period;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/afs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afs_ctrl
// Sequencer state machine: accepts items, walks frames, runs the period sum
// and the remainder unit, and hands the result to the output register.
// ----------------------------------------------------------------------------
module afs_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire afs_pkg::dp_status_t status_i,
  output afs_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_SUM_RD,
    S_SUM_ACC,
    S_MOD_CHK,
    S_DIV,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d       = state_q;
    cmd_o.op      = afs_pkg::DP_NOP;
    cmd_o.rd_sel  = afs_pkg::RD_CUR;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (status_i.op)
            afs_pkg::OP_TICK: begin
              cmd_o.op = afs_pkg::DP_TICK_START;
              state_d  = status_i.count_zero ? S_RESP : S_WALK_RD;
            end
            afs_pkg::OP_RESTART: begin
              cmd_o.op = afs_pkg::DP_RESTART;
              state_d  = S_RESP;
            end
            afs_pkg::OP_WRITE: begin
              cmd_o.op = afs_pkg::DP_WRITE;
              state_d  = S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_WALK_RD: begin
        cmd_o.rd_sel = afs_pkg::RD_CUR;
        state_d      = S_WALK_CMP;
      end
      S_WALK_CMP: begin
        if (status_i.covers) begin
          cmd_o.op = afs_pkg::DP_STEP;
          if (!status_i.last_frame) begin
            state_d = S_WALK_RD;
          end else if (status_i.loop_en) begin
            state_d = S_SUM_RD;
          end else begin
            state_d = S_RESP;
          end
        end else begin
          state_d = S_RESP;
        end
      end
      S_SUM_RD: begin
        cmd_o.rd_sel = afs_pkg::RD_IDX;
        state_d      = S_SUM_ACC;
      end
      S_SUM_ACC: begin
        cmd_o.op = afs_pkg::DP_SUM_ACC;
        state_d  = status_i.sum_last ? S_MOD_CHK : S_SUM_RD;
      end
      S_MOD_CHK: begin
        if (status_i.time_ge_period) begin
          cmd_o.op = afs_pkg::DP_DIV_START;
          state_d  = S_DIV;
        end else begin
          state_d = S_WALK_RD;
        end
      end
      S_DIV: begin
        cmd_o.op = afs_pkg::DP_DIV_STEP;
        if (status_i.div_last) begin
          state_d = S_WALK_RD;
        end
      end
      S_RESP: begin
        if (status_i.out_free) begin
          cmd_o.op = afs_pkg::DP_OUT_LOAD;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/afs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afs_datapath
// Duration table, frame and time registers, period accumulator, bit-serial
// remainder unit, configuration registers and the output register.
// ----------------------------------------------------------------------------
module afs_datapath #(
  parameter int MAX_FRAMES = afs_pkg::DEFAULT_MAX_FRAMES
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [afs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [afs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [afs_pkg::OP_W-1:0]          op_i,
  input  wire logic [afs_pkg::ELAPSED_W-1:0]     elapsed_ms_i,
  input  wire logic [afs_pkg::SLOT_W-1:0]        frame_slot_i,
  input  wire logic [afs_pkg::DUR_W-1:0]         frame_duration_i,
  input  wire afs_pkg::dp_cmd_t                  cmd_i,
  output afs_pkg::dp_status_t                    status_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [afs_pkg::INDEX_W-1:0]            frame_index_o,
  output logic                                   finished_o
);

  localparam int AddrW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CountW   = afs_pkg::COUNT_W;
  localparam int TimeW    = afs_pkg::TIME_W;
  localparam int PeriodW  = afs_pkg::PERIOD_W;
  localparam int DurW     = afs_pkg::DUR_W;

  // control state
  logic                 loop_q, loop_d;
  logic [CountW-1:0]    fc_q, fc_d;
  logic [CountW-1:0]    cur_q, cur_d;
  logic [TimeW-1:0]     time_q, time_d;
  logic                 fin_q, fin_d;
  logic                 out_valid_q, out_valid_d;

  // working registers
  logic [PeriodW-1:0]               period_q, period_d;
  logic [CountW-1:0]                idx_q, idx_d;
  logic [PeriodW-1:0]               rem_q, rem_d;
  logic [TimeW-1:0]                 div_q, div_d;
  logic [afs_pkg::DIV_CNT_W-1:0]    div_cnt_q, div_cnt_d;
  logic [afs_pkg::INDEX_W-1:0]      out_frame_q, out_frame_d;
  logic                             out_fin_q, out_fin_d;

  // duration table
  logic [DurW-1:0] mem [MAX_FRAMES];
  logic [DurW-1:0] rdata_q;
  logic [AddrW-1:0] raddr;
  logic             wr_en;

  logic [CountW-1:0]  count;
  logic [DurW-1:0]    dur_fix;
  logic [TimeW:0]     sat_sum;
  logic [PeriodW:0]   div_try;
  logic [PeriodW:0]   div_sub;
  logic [PeriodW-1:0] rem_next;

  // frame count limited to the table depth
  always_comb begin
    if (int'(fc_q) > MAX_FRAMES) begin
      count = CountW'(MAX_FRAMES);
    end else begin
      count = fc_q;
    end
  end

  // a zero duration counts as one
  assign dur_fix = (rdata_q == '0) ? DurW'(1) : rdata_q;

  // saturating time accumulate
  assign sat_sum = {1'b0, time_q} + (TimeW+1)'(elapsed_ms_i);

  // one restoring remainder step
  assign div_try  = {rem_q, div_q[TimeW-1]};
  assign div_sub  = div_try - {1'b0, period_q};
  assign rem_next = (div_try >= {1'b0, period_q}) ? div_sub[PeriodW-1:0]
                                                  : div_try[PeriodW-1:0];

  // status toward the controller
  always_comb begin
    status_o.op             = afs_pkg::op_e'(op_i);
    status_o.count_zero     = (count == '0);
    status_o.covers         = (time_q >= {{(TimeW-DurW){1'b0}}, dur_fix});
    status_o.last_frame     = (({1'b0, cur_q} + (CountW+1)'(1)) >= {1'b0, count});
    status_o.loop_en        = loop_q;
    status_o.sum_last       = (idx_q == (count - CountW'(1)));
    status_o.time_ge_period = (time_q >= {{(TimeW-PeriodW){1'b0}}, period_q});
    status_o.div_last       = (div_cnt_q == '1);
    status_o.out_free       = !out_valid_q || out_ready_i;
  end

  // table port
  assign raddr = (cmd_i.rd_sel == afs_pkg::RD_IDX) ? AddrW'(idx_q) : AddrW'(cur_q);
  assign wr_en = (cmd_i.op == afs_pkg::DP_WRITE) && (int'(frame_slot_i) < MAX_FRAMES);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AddrW'(frame_slot_i)] <= frame_duration_i;
    end
    rdata_q <= mem[raddr];
  end

  // next-state logic
  always_comb begin
    loop_d      = loop_q;
    fc_d        = fc_q;
    cur_d       = cur_q;
    time_d      = time_q;
    fin_d       = fin_q;
    period_d    = period_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    div_d       = div_q;
    div_cnt_d   = div_cnt_q;
    out_frame_d = out_frame_q;
    out_fin_d   = out_fin_q;
    out_valid_d = out_valid_q;

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        afs_pkg::CFG_LOOP_ENABLE: loop_d = cfg_data_i[0];
        afs_pkg::CFG_FRAME_COUNT: fc_d   = cfg_data_i;
        default: ;
      endcase
    end

    // result taken by the receiver
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (cmd_i.op)
      afs_pkg::DP_TICK_START: begin
        if (count != '0) begin
          if (cur_q >= count) begin
            cur_d = count - CountW'(1);
          end
          time_d = sat_sum[TimeW] ? '1 : sat_sum[TimeW-1:0];
        end
      end
      afs_pkg::DP_RESTART: begin
        cur_d  = '0;
        time_d = '0;
        fin_d  = 1'b0;
      end
      afs_pkg::DP_STEP: begin
        time_d = time_q - {{(TimeW-DurW){1'b0}}, dur_fix};
        if (!status_o.last_frame) begin
          cur_d = cur_q + CountW'(1);
        end else if (loop_q) begin
          // wrap, then sum the sequence period
          cur_d    = '0;
          period_d = '0;
          idx_d    = '0;
        end else begin
          fin_d = 1'b1;
          cur_d = count - CountW'(1);
        end
      end
      afs_pkg::DP_SUM_ACC: begin
        period_d = period_q + PeriodW'(dur_fix);
        idx_d    = idx_q + CountW'(1);
      end
      afs_pkg::DP_DIV_START: begin
        div_d     = time_q;
        rem_d     = '0;
        div_cnt_d = '0;
      end
      afs_pkg::DP_DIV_STEP: begin
        rem_d     = rem_next;
        div_d     = {div_q[TimeW-2:0], 1'b0};
        div_cnt_d = div_cnt_q + afs_pkg::DIV_CNT_W'(1);
        if (status_o.div_last) begin
          time_d = {{(TimeW-PeriodW){1'b0}}, rem_next};
        end
      end
      afs_pkg::DP_OUT_LOAD: begin
        out_frame_d = cur_q[afs_pkg::INDEX_W-1:0];
        out_fin_d   = fin_q & ~loop_q;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q      <= 1'b0;
      fc_q        <= '0;
      cur_q       <= '0;
      time_q      <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      loop_q      <= loop_d;
      fc_q        <= fc_d;
      cur_q       <= cur_d;
      time_q      <= time_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    period_q    <= period_d;
    idx_q       <= idx_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    div_cnt_q   <= div_cnt_d;
    out_frame_q <= out_frame_d;
    out_fin_q   <= out_fin_d;
  end

  assign out_valid_o   = out_valid_q;
  assign frame_index_o = out_frame_q;
  assign finished_o    = out_fin_q;

endmodule
`default_nettype wire

### rtl/core/animation_frame_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// animation_frame_sequencer
// Sprite animation frame sequencer with a per-frame duration table.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel, one at a time; the operation code
//   rides on tuser (tick, restart, write duration entry). Each item yields
//   exactly one result item on m_axis with the shown frame and the finished
//   flag. The user must write loop_enable (index 0) and frame_count
//   (index 1) on the cfg port only while no item is in flight; the block
//   itself does not enforce this. Restart, write, unused codes and a tick
//   with zero frames go straight to the result. Any other tick walks the
//   frames step by step while the time covers the current frame's duration;
//   one-shot play ends on its last step, and each wrap in loop mode runs
//   the period sum over the frames and, when the time is at least the
//   period, the remainder unit, which reduces the time one bit a cycle.
//   The next item is accepted in the cycle after its result is loaded.
//   The duration table has a single read port.
//   s_axis_tready is high only while the sequencer is idle; it stays high
//   while an earlier result waits in the output register. When the
//   receiver stalls, the next result is held until that register is free.
//   Reset clears frame, time, finished flag and both registers; the
//   duration table keeps no reset value and must be written before use.
// ----------------------------------------------------------------------------
module animation_frame_sequencer #(
  parameter int MAX_FRAMES = afs_pkg::DEFAULT_MAX_FRAMES
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [afs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [afs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input items
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [15:0] elapsed_ms, [19:16] frame_slot, [35:20] frame_duration, zero pad
  input  wire logic [afs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] operation
  input  wire logic [afs_pkg::OP_W-1:0]          s_axis_tuser,
  // result items
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [3:0] frame_index, [4] finished, zero pad
  output logic [afs_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

  afs_pkg::dp_cmd_t                 cmd;
  afs_pkg::dp_status_t              status;
  logic [afs_pkg::INDEX_W-1:0]      frame_index;
  logic                             finished;

  afs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  afs_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (s_axis_tuser),
    .elapsed_ms_i     (s_axis_tdata[15:0]),
    .frame_slot_i     (s_axis_tdata[19:16]),
    .frame_duration_i (s_axis_tdata[35:20]),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .frame_index_o    (frame_index),
    .finished_o       (finished)
  );

  // result packing
  assign m_axis_tdata = {3'b000, finished, frame_index};

endmodule
`default_nettype wire

### rtl/core/afs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// afs_checker
// Port-level checks of the frame sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module afs_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [afs_pkg::OP_W-1:0]       s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [afs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while busy");

  // restart with an empty output register shows frame zero, not finished
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
    (s_axis_tuser == afs_pkg::OP_RESTART)
    |=> ##1 (m_axis_tvalid && (m_axis_tdata[3:0] == 4'd0) && !m_axis_tdata[4]))
    else $error("restart result wrong");

endmodule

bind animation_frame_sequencer afs_checker u_afs_checker (.*);
`default_nettype wire
